/* rtl/assert_macros.svh */
// Assertion macros shared by the deframer RTL.
// Depends on i_clk and i_rst_n being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/hfd_pkg.sv */
// Types, constants and the CRC-16 byte update for the frame deframer.
// No dependencies; imported by hfd_parser, hfd_out_reg and the top level.
`timescale 1ns / 1ps
`default_nettype none

package hfd_pkg;

    // CRC-16/CCITT-FALSE parameters and the version that carries a CRC.
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [7:0]  CRC_VERSION = 8'd2;

    // Head byte after reset.
    localparam logic [7:0]  HEAD_RESET  = 8'hAA;

    // Status codes of a closing result.
    localparam logic [1:0]  ST_OK       = 2'd0;
    localparam logic [1:0]  ST_BAD_HEAD = 2'd1;
    localparam logic [1:0]  ST_CRC_BAD  = 2'd2;

    // Parser phases, one-hot.
    typedef enum logic [6:0] {
        PH_HUNT = 7'b0000001,
        PH_VER  = 7'b0000010,
        PH_SEQ  = 7'b0000100,
        PH_LEN  = 7'b0001000,
        PH_BODY = 7'b0010000,
        PH_CRCH = 7'b0100000,
        PH_CRCL = 7'b1000000
    } t_phase;

    // One result item.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       frame_end;
        logic [1:0] status;
        logic [7:0] version;
        logic [7:0] sequence_res;
        logic [7:0] body_length;
    } t_result;

    // MSB-first CRC update over one byte, eight bit steps unrolled.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = b[k] ^ c[15];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/hfd_rx_if.sv */
// Byte input channel of the deframer: valid, ready and one received byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/hfd_res_if.sv */
// Result channel of the deframer: valid, ready and the result fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hfd_res_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       frame_end;
    logic [1:0] status;
    logic [7:0] version;
    logic [7:0] sequence_res;
    logic [7:0] body_length;

    modport source (
        output valid, output byte_valid, output data_byte, output frame_end,
        output status, output version, output sequence_res, output body_length,
        input ready
    );
    modport sink (
        input valid, input byte_valid, input data_byte, input frame_end,
        input status, input version, input sequence_res, input body_length,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/hfd_cfg_if.sv */
// Configuration write channel of the deframer: valid, ready and the head byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] head_byte;

    modport source (output valid, output head_byte, input ready);
    modport sink (input valid, input head_byte, output ready);
endinterface

`default_nettype wire

/* rtl/hfd_in_reg.sv */
// Input register stage: holds one received byte until the parser takes it.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
`default_nettype none

module hfd_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    output logic            o_ready,
    input  wire logic       i_take,
    output logic            o_valid,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // A new byte can enter when the stage is empty or is being emptied.
    assign o_ready = !r_valid || i_take;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Byte payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

/* rtl/hfd_parser.sv */
// Frame parser: phase register, header fields and running CRC, and the
// combinational result for the byte being processed. Depends on hfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hfd_parser
    import hfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_head_byte,
    output logic            o_has_result,
    output t_result         o_result
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_version, n_version;
    logic [7:0]  r_sequence, n_sequence;
    logic [7:0]  r_length, n_length;
    logic [7:0]  r_left, n_left;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_high, n_crc_high;
    logic [7:0]  w_left_dec;

    assign w_left_dec = r_left - 8'd1;

    // Next state and result for the current byte.
    always_comb begin
        n_phase      = r_phase;
        n_version    = r_version;
        n_sequence   = r_sequence;
        n_length     = r_length;
        n_left       = r_left;
        n_crc        = r_crc;
        n_crc_high   = r_crc_high;
        o_has_result = 1'b0;
        o_result     = '0;
        case (r_phase)
            PH_VER: begin
                n_version = i_byte;
                n_phase   = PH_SEQ;
            end
            PH_SEQ: begin
                n_sequence = i_byte;
                n_phase    = PH_LEN;
            end
            PH_LEN: begin
                n_length = i_byte;
                n_left   = i_byte;
                if (i_byte != 8'd0) begin
                    n_phase = PH_BODY;
                end else if (r_version == CRC_VERSION) begin
                    n_phase = PH_CRCH;
                end else begin
                    // Empty body without CRC closes the frame here.
                    n_phase               = PH_HUNT;
                    o_has_result          = 1'b1;
                    o_result.frame_end    = 1'b1;
                    o_result.status       = ST_OK;
                    o_result.version      = r_version;
                    o_result.sequence_res = r_sequence;
                    o_result.body_length  = i_byte;
                end
            end
            PH_BODY: begin
                n_crc                 = crc_byte(r_crc, i_byte);
                n_left                = w_left_dec;
                o_has_result          = 1'b1;
                o_result.byte_valid   = 1'b1;
                o_result.data_byte    = i_byte;
                o_result.version      = r_version;
                o_result.sequence_res = r_sequence;
                o_result.body_length  = r_length;
                if (w_left_dec == 8'd0) begin
                    if (r_version == CRC_VERSION) begin
                        n_phase = PH_CRCH;
                    end else begin
                        n_phase            = PH_HUNT;
                        o_result.frame_end = 1'b1;
                    end
                end
            end
            PH_CRCH: begin
                n_crc_high = i_byte;
                n_phase    = PH_CRCL;
            end
            PH_CRCL: begin
                n_phase               = PH_HUNT;
                o_has_result          = 1'b1;
                o_result.frame_end    = 1'b1;
                o_result.status       = ({r_crc_high, i_byte} == r_crc) ? ST_OK : ST_CRC_BAD;
                o_result.version      = r_version;
                o_result.sequence_res = r_sequence;
                o_result.body_length  = r_length;
            end
            default: begin
                // Hunting for the head byte; unknown codes hunt as well.
                n_phase = PH_HUNT;
                if (i_byte == i_head_byte) begin
                    n_crc   = CRC_INIT;
                    n_phase = PH_VER;
                end else begin
                    o_has_result       = 1'b1;
                    o_result.frame_end = 1'b1;
                    o_result.status    = ST_BAD_HEAD;
                end
            end
        endcase
    end

    // State update when a byte is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_version  <= '0;
            r_sequence <= '0;
            r_length   <= '0;
            r_left     <= '0;
            r_crc      <= CRC_INIT;
            r_crc_high <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_version  <= n_version;
            r_sequence <= n_sequence;
            r_length   <= n_length;
            r_left     <= n_left;
            r_crc      <= n_crc;
            r_crc_high <= n_crc_high;
        end
    end

    // A nonzero status only appears on a frame-closing result.
    `ASSERT_CLK(a_status_needs_end, o_has_result && (o_result.status != ST_OK) |-> o_result.frame_end, "status without frame end")
    // A bad head result only comes while hunting.
    `ASSERT_CLK(a_bad_head_in_hunt, o_has_result && (o_result.status == ST_BAD_HEAD) |-> (r_phase == PH_HUNT), "bad head outside hunt")
    // The CRC low byte always returns the parser to hunting.
    `ASSERT_CLK(a_crcl_to_hunt, i_fire && (r_phase == PH_CRCL) |=> (r_phase == PH_HUNT), "CRC low did not close frame")

endmodule

`default_nettype wire

/* rtl/hfd_out_reg.sv */
// Result register: holds one result until the receiver takes it.
// Depends on hfd_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module hfd_out_reg
    import hfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    // Occupancy flag: a load wins over the drain of the previous result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* rtl/hex_frame_deframer_crc16_top.sv */
// Top level of the length-prefixed frame deframer with CRC-16 check.
// Usage:
//   i_rx carries one received byte per transfer (valid/ready). o_res carries
//   result items: body bytes as they arrive and one closing result per frame
//   with version, sequence, length and status (ok, bad head, CRC mismatch).
//   A body byte emitted before an error must be dropped by the receiver.
//   i_cfg writes the expected head byte; its ready is always high. The user
//   must write it only while the block is idle; the block does not enforce this.
// Timing:
//   A byte held in the input register is processed once the result register is
//   free or draining; its result, if any, is registered then and shown on o_res.
//   One byte per cycle is sustained while o_res is taken; the rate is set by the
//   parser step, which updates the CRC over a whole byte at once.
// Reset:
//   Synchronous, active low. Both registers empty, the parser hunts for a
//   head byte, the head byte returns to 0xAA.
// Stall:
//   When o_res is not taken, the result register holds; the input register
//   still takes one more byte, then i_rx.ready drops until space frees up.
// Depends on hfd_pkg, the three channel interfaces, hfd_in_reg, hfd_parser
// and hfd_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module hex_frame_deframer_crc16_top
    import hfd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hfd_rx_if.sink    i_rx,
    hfd_cfg_if.sink   i_cfg,
    hfd_res_if.source o_res
);

    logic [7:0] r_head;
    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_fire;
    logic       w_has_result;
    t_result    w_result;
    logic       w_out_valid;
    t_result    w_out_result;

    // Head byte register; the write port never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= HEAD_RESET;
        end else if (i_cfg.valid) begin
            r_head <= i_cfg.head_byte;
        end
    end

    // A held byte is processed when the result register is free or draining.
    assign w_fire = w_in_valid && (!w_out_valid || o_res.ready);

    hfd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .i_byte  (i_rx.rx_byte),
        .o_ready (i_rx.ready),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    hfd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_byte       (w_in_byte),
        .i_head_byte  (r_head),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    hfd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire && w_has_result),
        .i_result (w_result),
        .i_ready  (o_res.ready),
        .o_valid  (w_out_valid),
        .o_result (w_out_result)
    );

    // Result channel.
    assign o_res.valid        = w_out_valid;
    assign o_res.byte_valid   = w_out_result.byte_valid;
    assign o_res.data_byte    = w_out_result.data_byte;
    assign o_res.frame_end    = w_out_result.frame_end;
    assign o_res.status       = w_out_result.status;
    assign o_res.version      = w_out_result.version;
    assign o_res.sequence_res = w_out_result.sequence_res;
    assign o_res.body_length  = w_out_result.body_length;

endmodule

`default_nettype wire

/* sim/hex_frame_deframer_crc16_top_tb.sv */
// Self-checking testbench for hex_frame_deframer_crc16_top: directed frames, then random
// frame streams under several head bytes, checked against a cycle-free frame predictor.
// Depends on hfd_pkg and the hfd_rx_if, hfd_cfg_if and hfd_res_if channel interfaces.
`timescale 1ns / 1ps

module hex_frame_deframer_crc16_top_tb;
    import hfd_pkg::*;

    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 265;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES  = 200;
    localparam int RUN_LIMIT_NS = 5_000_000;

    typedef enum int {
        ROW_PREDICT,
        ROW_SILENT,
        ROW_FIXED
    } t_row_kind;

    typedef struct {
        logic [7:0] rx_byte;
        t_row_kind  kind;
        t_result    res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hfd_rx_if  rx_ch ();
    hfd_cfg_if cfg_ch ();
    hfd_res_if res_ch ();

    hex_frame_deframer_crc16_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // Free-running clock, 4 ns period.
    always #2 i_clk = ~i_clk;

    // Frame predictor state, mirrors what the parser should hold.
    t_phase      frm_phase;
    logic [7:0]  frm_head;
    logic [7:0]  frm_ver;
    logic [7:0]  frm_seq;
    logic [7:0]  frm_len;
    logic [7:0]  frm_left;
    logic [15:0] frm_crc;
    logic [7:0]  frm_crc_hi;

    t_result frame_results_q[$];
    t_row    directed_rows[$];

    int  err_count  = 0;
    int  tx_items   = 0;
    int  ok_frames  = 0;
    int  head_errs  = 0;
    int  crc_errs   = 0;
    int  body_bytes = 0;
    bit  quiet_tx   = 1'b0;
    bit  quiet_rx   = 1'b0;
    bit  hold_req   = 1'b0;

    // CRC-16/CCITT-FALSE over one byte, shifted in a whole byte at a time.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        repeat (8) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    // A closing result with no body byte attached.
    function automatic t_result close_result(input logic [1:0] st, input logic [7:0] ver,
                                             input logic [7:0] seq, input logic [7:0] len);
        t_result res;
        res              = '0;
        res.frame_end    = 1'b1;
        res.status       = st;
        res.version      = ver;
        res.sequence_res = seq;
        res.body_length  = len;
        return res;
    endfunction

    // Advances the frame predictor by one byte; returns 1 when a result is due.
    function automatic bit deframe_step(input logic [7:0] b, output t_result res);
        bit has_res;
        res     = '0;
        has_res = 1'b0;
        case (frm_phase)
            PH_VER: begin
                frm_ver   = b;
                frm_phase = PH_SEQ;
            end
            PH_SEQ: begin
                frm_seq   = b;
                frm_phase = PH_LEN;
            end
            PH_LEN: begin
                frm_len  = b;
                frm_left = b;
                if (b != 8'd0) begin
                    frm_phase = PH_BODY;
                end else if (frm_ver == CRC_VERSION) begin
                    frm_phase = PH_CRCH;
                end else begin
                    frm_phase = PH_HUNT;
                    res       = close_result(ST_OK, frm_ver, frm_seq, frm_len);
                    has_res   = 1'b1;
                end
            end
            PH_BODY: begin
                frm_crc  = crc16_update(frm_crc, b);
                frm_left = frm_left - 8'd1;
                res      = close_result(ST_OK, frm_ver, frm_seq, frm_len);
                res.frame_end  = 1'b0;
                res.byte_valid = 1'b1;
                res.data_byte  = b;
                has_res  = 1'b1;
                if (frm_left == 8'd0) begin
                    if (frm_ver == CRC_VERSION) begin
                        frm_phase = PH_CRCH;
                    end else begin
                        frm_phase     = PH_HUNT;
                        res.frame_end = 1'b1;
                    end
                end
            end
            PH_CRCH: begin
                frm_crc_hi = b;
                frm_phase  = PH_CRCL;
            end
            PH_CRCL: begin
                frm_phase = PH_HUNT;
                res = close_result(({frm_crc_hi, b} == frm_crc) ? ST_OK : ST_CRC_BAD,
                                   frm_ver, frm_seq, frm_len);
                has_res = 1'b1;
            end
            default: begin
                frm_phase = PH_HUNT;
                if (b == frm_head) begin
                    frm_crc   = CRC_INIT;
                    frm_phase = PH_VER;
                end else begin
                    res     = close_result(ST_BAD_HEAD, 8'h00, 8'h00, 8'h00);
                    has_res = 1'b1;
                end
            end
        endcase
        return has_res;
    endfunction

    function automatic void add_row(input logic [7:0] b, input t_row_kind kind,
                                    input t_result res);
        directed_rows.push_back('{b, kind, res});
    endfunction

    // Offers one byte and waits for its transfer; the expectation is queued at that edge.
    task automatic send_byte(input logic [7:0] b, input t_row_kind kind, input t_result fixed);
        t_result res;
        bit      has_res;
        @(negedge i_clk);
        rx_ch.valid   = 1'b1;
        rx_ch.rx_byte = b;
        do @(posedge i_clk); while (rx_ch.ready !== 1'b1);
        tx_items++;
        has_res = deframe_step(b, res);
        if (kind == ROW_FIXED) begin
            frame_results_q.push_back(fixed);
        end else if (kind == ROW_PREDICT && has_res) begin
            frame_results_q.push_back(res);
        end
    endtask

    // Random gap after a transfer: mostly none, sometimes short, rarely long.
    task automatic idle_tx();
        int r;
        int n;
        if (quiet_tx) return;
        r = $urandom_range(0, 99);
        n = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(6, 30);
        if (n > 0) begin
            @(negedge i_clk);
            rx_ch.valid   = 1'b0;
            rx_ch.rx_byte = 8'($urandom);
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Stops offering and waits until every expected result has been taken.
    task automatic wait_drained();
        @(negedge i_clk);
        rx_ch.valid = 1'b0;
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the head byte register; only called while the block is idle.
    task automatic write_head(input logic [7:0] head);
        @(negedge i_clk);
        cfg_ch.valid     = 1'b1;
        cfg_ch.head_byte = head;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        frm_head = head;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Builds one frame with random content, optionally cut short, and sends it.
    task automatic send_frame(input bit truncate);
        logic [7:0]  fq[$];
        logic [7:0]  ver;
        logic [7:0]  len;
        logic [7:0]  b;
        logic [15:0] crc;
        int          r;
        int          cut;
        ver = ($urandom_range(0, 1) == 1) ? CRC_VERSION : 8'($urandom);
        r   = $urandom_range(0, 99);
        if (r < 60) begin
            len = 8'($urandom_range(0, 6));
        end else if (r < 90) begin
            len = 8'($urandom_range(7, 40));
        end else if (r < 98) begin
            len = 8'($urandom_range(41, 120));
        end else if (r == 98) begin
            len = 8'($urandom_range(200, 254));
        end else begin
            len = 8'd255;
        end
        fq.push_back(frm_head);
        fq.push_back(ver);
        fq.push_back(8'($urandom));
        fq.push_back(len);
        crc = CRC_INIT;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            fq.push_back(b);
            crc = crc16_update(crc, b);
        end
        // Version 2 carries the CRC; some of them are corrupted on purpose.
        if (ver == CRC_VERSION) begin
            if ($urandom_range(0, 99) < 15) begin
                crc = crc ^ (16'd1 << $urandom_range(0, 15));
            end
            fq.push_back(crc[15:8]);
            fq.push_back(crc[7:0]);
        end
        if (truncate) begin
            cut = $urandom_range(1, fq.size() - 1);
            fq  = fq[0:cut-1];
        end
        foreach (fq[i]) begin
            send_byte(fq[i], ROW_PREDICT, '0);
            idle_tx();
        end
    endtask

    // Result checker: every transfer on o_res is compared with the oldest expectation.
    always @(posedge i_clk) begin : res_check
        t_result want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (frame_results_q.size() == 0) begin
                $error("result transfer with no expected result pending");
                err_count++;
            end else begin
                want = frame_results_q.pop_front();
                if (res_ch.byte_valid !== want.byte_valid) begin
                    $error("byte_valid: expected %0h, got %0h", want.byte_valid,
                           res_ch.byte_valid);
                    err_count++;
                end
                if (res_ch.data_byte !== want.data_byte) begin
                    $error("data_byte: expected %0h, got %0h", want.data_byte,
                           res_ch.data_byte);
                    err_count++;
                end
                if (res_ch.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0h, got %0h", want.frame_end,
                           res_ch.frame_end);
                    err_count++;
                end
                if (res_ch.status !== want.status) begin
                    $error("status: expected %0h, got %0h", want.status, res_ch.status);
                    err_count++;
                end
                if (res_ch.version !== want.version) begin
                    $error("version: expected %0h, got %0h", want.version, res_ch.version);
                    err_count++;
                end
                if (res_ch.sequence_res !== want.sequence_res) begin
                    $error("sequence_res: expected %0h, got %0h", want.sequence_res,
                           res_ch.sequence_res);
                    err_count++;
                end
                if (res_ch.body_length !== want.body_length) begin
                    $error("body_length: expected %0h, got %0h", want.body_length,
                           res_ch.body_length);
                    err_count++;
                end
                if (want.byte_valid) body_bytes++;
                if (want.frame_end) begin
                    case (want.status)
                        ST_OK:       ok_frames++;
                        ST_BAD_HEAD: head_errs++;
                        default:     crc_errs++;
                    endcase
                end
            end
        end
    end

    // Result receiver: random stalls, quiet stretches, and one long hold on request.
    initial begin : res_sink
        int stall_left;
        int r;
        res_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_ch.ready = 1'b0;
                stall_left--;
            end else if (hold_req) begin
                res_ch.ready = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                hold_req     = 1'b0;
            end else if (quiet_rx) begin
                res_ch.ready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    res_ch.ready = 1'b1;
                end else begin
                    res_ch.ready = 1'b0;
                    stall_left   = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("hex_frame_deframer_crc16_top_tb: done, errors");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases under different head bytes.
    initial begin : main_seq
        logic [7:0] phase_heads[NUM_PHASES];
        int         phase_start;
        int         r;
        bit         paused;

        rx_ch.valid      = 1'b0;
        rx_ch.rx_byte    = 8'h00;
        cfg_ch.valid     = 1'b0;
        cfg_ch.head_byte = 8'h00;
        i_rst_n          = 1'b0;

        frm_phase  = PH_HUNT;
        frm_head   = HEAD_RESET;
        frm_ver    = 8'h00;
        frm_seq    = 8'h00;
        frm_len    = 8'h00;
        frm_left   = 8'h00;
        frm_crc    = CRC_INIT;
        frm_crc_hi = 8'h00;

        // Wrong head bytes at both extremes, then the reset head byte opens frames.
        add_row(8'h00, ROW_FIXED, close_result(ST_BAD_HEAD, 8'h00, 8'h00, 8'h00));
        add_row(8'hFF, ROW_FIXED, close_result(ST_BAD_HEAD, 8'h00, 8'h00, 8'h00));
        // Empty body without CRC: the length byte closes the frame.
        add_row(HEAD_RESET, ROW_SILENT, '0);
        add_row(8'h01, ROW_SILENT, '0);
        add_row(8'h7E, ROW_SILENT, '0);
        add_row(8'h00, ROW_FIXED, close_result(ST_OK, 8'h01, 8'h7E, 8'h00));
        // Empty body with CRC: the CRC must equal the initial value.
        add_row(HEAD_RESET, ROW_SILENT, '0);
        add_row(CRC_VERSION, ROW_SILENT, '0);
        add_row(8'h80, ROW_SILENT, '0);
        add_row(8'h00, ROW_SILENT, '0);
        add_row(8'hFF, ROW_SILENT, '0);
        add_row(8'hFF, ROW_FIXED, close_result(ST_OK, CRC_VERSION, 8'h80, 8'h00));
        // Two body bytes with a wrong CRC.
        add_row(HEAD_RESET, ROW_SILENT, '0);
        add_row(CRC_VERSION, ROW_SILENT, '0);
        add_row(8'hFF, ROW_SILENT, '0);
        add_row(8'h02, ROW_SILENT, '0);
        add_row(8'h00, ROW_PREDICT, '0);
        add_row(8'hFF, ROW_PREDICT, '0);
        add_row(8'h12, ROW_SILENT, '0);
        add_row(8'h34, ROW_FIXED, close_result(ST_CRC_BAD, CRC_VERSION, 8'hFF, 8'h02));
        // One body byte without CRC: body byte and close share a result.
        add_row(HEAD_RESET, ROW_SILENT, '0);
        add_row(8'h05, ROW_SILENT, '0);
        add_row(8'h11, ROW_SILENT, '0);
        add_row(8'h01, ROW_SILENT, '0);
        add_row(8'h55, ROW_PREDICT, '0);

        phase_heads[0] = 8'h00;
        phase_heads[1] = 8'hFF;
        phase_heads[2] = HEAD_RESET;
        phase_heads[3] = 8'($urandom);
        phase_heads[4] = 8'($urandom);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].rx_byte, directed_rows[i].kind, directed_rows[i].res);
            idle_tx();
        end
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_head(phase_heads[p]);
            // One phase runs with no idling on either side.
            quiet_tx    = (p == 2);
            quiet_rx    = (p == 2);
            phase_start = tx_items;
            paused      = 1'b0;
            while (tx_items - phase_start < PHASE_ITEMS) begin
                // Long output hold while the input keeps offering, so the block backs up.
                if (p == 1 && !paused && tx_items - phase_start > 50) begin
                    paused   = 1'b1;
                    hold_req = 1'b1;
                    quiet_tx = 1'b1;
                    repeat (3) send_frame(1'b0);
                    quiet_tx = 1'b0;
                end
                // Pause the input until every pending result is out.
                if (p == 3 && !paused && tx_items - phase_start > PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    wait_drained();
                end
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_byte(8'($urandom), ROW_PREDICT, '0);
                        idle_tx();
                    end
                end else begin
                    send_frame(r < 20);
                end
            end
            wait_drained();
        end

        $display("Sent %0d bytes over %0d head settings; %0d body bytes, %0d frames ok.",
                 tx_items, NUM_PHASES + 1, body_bytes, ok_frames);
        $display("Closed with errors: %0d wrong head bytes, %0d CRC mismatches.",
                 head_errs, crc_errs);
        if (err_count == 0) begin
            $display("hex_frame_deframer_crc16_top_tb: done, clean");
        end else begin
            $display("hex_frame_deframer_crc16_top_tb: done, errors");
        end
        $finish;
    end

endmodule
